// ===== rtl/multilevel_queue_slot_scheduler_defines.svh =====
// assertion helpers for the multilevel queue slot scheduler
`ifndef MULTILEVEL_QUEUE_SLOT_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_QUEUE_SLOT_SCHEDULER_DEFINES_SVH

// property that holds in the same cycle
`define MLQS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequent holds in the next cycle
`define MLQS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mlqs_pkg.sv =====
package mlqs_pkg;

  localparam int unsigned MLQS_NUM_PRIO    = 8;
  localparam int unsigned MLQS_QUEUE_DEPTH = 16;
  localparam int unsigned MLQS_ID_BITS     = 8;

  localparam int unsigned PID_W    = 8;
  localparam int unsigned PRIO_W   = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_DONE
  } mlqs_state_e;

endpackage

// ===== rtl/multilevel_queue_slot_scheduler.sv =====
// channel  | valid       | stall       | beat fields
// ---------+-------------+-------------+--------------------------------------------
// in       | in_valid_i  | in_stall_o  | operation_i, process_id_i, priority_req_i
// out      | out_valid_o | out_stall_i | status_o, granted_id_o, granted_level_o
//
// enqueue steps: accept, queue update, result load
// dequeue steps: accept, a one-level-a-cycle scan from level 0 to the first level with entries and slots, result load
// a failed dequeue scans all NUM_PRIO levels and reloads every slot counter
// reset clears head and count of every level and loads each slot counter with NUM_PRIO - level
// in_stall_o is high while an item is in work; a result held by out_stall_i delays the next

`include "multilevel_queue_slot_scheduler_defines.svh"

module multilevel_queue_slot_scheduler
  import mlqs_pkg::*;
#(
  parameter int unsigned NUM_PRIO    = MLQS_NUM_PRIO,
  parameter int unsigned QUEUE_DEPTH = MLQS_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = MLQS_ID_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [PID_W-1:0]    process_id_i,
  input  logic [PRIO_W-1:0]   priority_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [PID_W-1:0]    granted_id_o,
  output logic [PRIO_W-1:0]   granted_level_o
);

  localparam int unsigned LVL_W  = (NUM_PRIO > 1) ? $clog2(NUM_PRIO) : 1;
  localparam int unsigned HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SLOT_W = $clog2(NUM_PRIO + 1);
  localparam int unsigned MEM_D  = NUM_PRIO * QUEUE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_D);

  mlqs_state_e state_q, state_d;

  logic                op_q;
  logic [ID_BITS-1:0]  pid_q;
  logic [LVL_W-1:0]    lvl_q, lvl_in;
  logic [LVL_W-1:0]    idx_q, idx_d;
  logic [STATUS_W-1:0] st_q, st_d;

  logic [HEAD_W-1:0] head_q [NUM_PRIO];
  logic [CNT_W-1:0]  count_q [NUM_PRIO];
  logic [SLOT_W-1:0] slot_q [NUM_PRIO];

  logic [ID_BITS-1:0] mem_q [MEM_D];
  logic [ID_BITS-1:0] rd_q;

  logic              accept;
  logic              enq_full, enq_do;
  logic              scan_hit, scan_last, reload;
  logic [HEAD_W:0]   pos_sum;
  logic [HEAD_W-1:0] wpos, head_nxt;
  logic [ADDR_W-1:0] waddr, raddr;
  logic              load_out;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PID_W-1:0]    out_id_q;
  logic [PRIO_W-1:0]   out_level_q;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    if (32'(priority_req_i) >= NUM_PRIO) begin
      lvl_in = LVL_W'(NUM_PRIO - 1);
    end else begin
      lvl_in = LVL_W'(priority_req_i);
    end
  end

  // enqueue position and address
  assign enq_full = (count_q[lvl_q] >= CNT_W'(QUEUE_DEPTH));
  assign pos_sum  = (HEAD_W+1)'(head_q[lvl_q]) + (HEAD_W+1)'(count_q[lvl_q]);
  assign wpos     = (pos_sum >= (HEAD_W+1)'(QUEUE_DEPTH)) ?
                    HEAD_W'(pos_sum - (HEAD_W+1)'(QUEUE_DEPTH)) : HEAD_W'(pos_sum);
  assign waddr    = ADDR_W'(lvl_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wpos);

  // dequeue scan, one level per cycle
  assign scan_hit  = (count_q[idx_q] != '0) && (slot_q[idx_q] != '0);
  assign scan_last = (idx_q == LVL_W'(NUM_PRIO - 1));
  assign head_nxt  = (32'(head_q[idx_q]) + 1 >= QUEUE_DEPTH) ? '0 : head_q[idx_q] + 1'b1;
  assign raddr     = ADDR_W'(idx_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[idx_q]);

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    st_d     = st_q;
    enq_do   = 1'b0;
    reload   = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          state_d = (operation_i == OP_DEQ) ? S_SCAN : S_ENQ;
        end
      end
      S_ENQ: begin
        if (enq_full) begin
          st_d = STATUS_FULL;
        end else begin
          st_d   = STATUS_OK;
          enq_do = 1'b1;
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          st_d    = STATUS_OK;
          state_d = S_DONE;
        end else if (scan_last) begin
          st_d    = STATUS_NONE;
          reload  = 1'b1;
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      pid_q <= ID_BITS'(process_id_i);
      lvl_q <= lvl_in;
    end
    idx_q <= idx_d;
    st_q  <= st_d;
  end

  // per-level head, count and slot counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PRIO; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
        slot_q[i]  <= SLOT_W'(NUM_PRIO - i);
      end
    end else begin
      if (enq_do) begin
        count_q[lvl_q] <= count_q[lvl_q] + 1'b1;
      end
      if (state_q == S_SCAN && scan_hit) begin
        head_q[idx_q]  <= head_nxt;
        count_q[idx_q] <= count_q[idx_q] - 1'b1;
        slot_q[idx_q]  <= slot_q[idx_q] - 1'b1;
      end
      if (reload) begin
        for (int i = 0; i < NUM_PRIO; i++) begin
          slot_q[i] <= SLOT_W'(NUM_PRIO - i);
        end
      end
    end
  end

  // queue memory
  always_ff @(posedge clk_i) begin
    if (enq_do) begin
      mem_q[waddr] <= pid_q;
    end
    if (state_q == S_SCAN && scan_hit) begin
      rd_q <= mem_q[raddr];
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= st_q;
      if (op_q == OP_DEQ && st_q == STATUS_OK) begin
        out_id_q    <= PID_W'(rd_q);
        out_level_q <= PRIO_W'(idx_q);
      end else begin
        out_id_q    <= '0;
        out_level_q <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign granted_id_o    = out_id_q;
  assign granted_level_o = out_level_q;

  `MLQS_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == S_DONE),
               "beat without finished item")
  `MLQS_ASSERT_NEXT(a_reload, (state_q == S_SCAN) && scan_last && !scan_hit,
                    slot_q[0] == SLOT_W'(NUM_PRIO), "slot counters not reloaded")
  `MLQS_ASSERT_NEXT(a_enq_count, (state_q == S_ENQ) && !enq_full,
                    count_q[lvl_q] == $past(count_q[lvl_q]) + 1'b1,
                    "enqueue did not grow queue")

endmodule
